FILE: rtl/task_delay_scheduler_assert.svh
// assertion macros used by the scheduler top module
// each macro expects i_clk and i_rst_n in scope
`ifndef TASK_DELAY_SCHEDULER_ASSERT_SVH
`define TASK_DELAY_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define TDS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TDS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tds_pkg.sv
package tds_pkg;

    // table geometry
    localparam int MAX_TASKS  = 8;
    localparam int DELAY_BITS = 32;
    localparam int ENT_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);
    // common width for index and count compares
    localparam int CMP_W      = 8;

    localparam logic [DELAY_BITS-1:0] NEVER_DELAY    = '1;
    localparam logic [3:0]            TASK_COUNT_RST = 4'd8;

    // command codes; query and unused codes change nothing
    localparam logic [2:0] MODE_SCHEDULE = 3'd0;
    localparam logic [2:0] MODE_ADVANCE  = 3'd1;
    localparam logic [2:0] MODE_DISPATCH = 3'd2;
    localparam logic [2:0] MODE_FINISH   = 3'd3;

    // command latched at accept, held for the whole sweep
    typedef struct packed {
        logic [2:0]            mode;
        logic [ENT_W-1:0]      idx;
        logic                  hit_ok;
        logic [DELAY_BITS-1:0] dv;
        logic [CNT_W-1:0]      n_use;
    } t_cmd;

    // sweep summary back to the control
    typedef struct packed {
        logic                  done;
        logic [MAX_TASKS-1:0]  due_mask;
        logic [DELAY_BITS-1:0] min_delay;
        logic                  run_pending;
    } t_sweep_sts;

endpackage

FILE: rtl/tds_delay_ram.sv
module tds_delay_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/tds_sweep.sv
module tds_sweep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  tds_pkg::t_cmd       i_cmd,
    output tds_pkg::t_sweep_sts o_sts
);

    localparam int NT = tds_pkg::MAX_TASKS;
    localparam int EW = tds_pkg::ENT_W;
    localparam int DW = tds_pkg::DELAY_BITS;
    localparam int CW = tds_pkg::CMP_W;

    // read issue stage
    logic          r_rd_busy;
    logic [EW-1:0] r_rd_idx;
    // modify stage, ram data valid here
    logic          r_b_vld;
    logic          r_b_last;
    logic [EW-1:0] r_b_idx;
    // min stage
    logic          r_c_vld;
    logic          r_c_last;
    logic          r_c_use;
    logic [DW-1:0] r_c_val;
    // summary
    logic          r_done;
    logic [DW-1:0] r_min;
    logic [NT-1:0] r_due;
    // per-entry flags: ram contents valid, run-now
    logic [NT-1:0] r_vbit;
    logic [NT-1:0] r_run;

    logic [DW-1:0] w_rdata;
    logic [DW-1:0] w_cur;
    logic [DW-1:0] n_val;
    logic          n_run;
    logic          n_due;
    logic          w_use;
    logic          w_hit;
    logic [NT-1:0] w_use_mask;

    tds_delay_ram #(
        .WIDTH (DW),
        .DEPTH (NT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_b_vld),
        .i_waddr (r_b_idx),
        .i_wdata (n_val),
        .i_re    (r_rd_busy),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    // read address walks every entry once; each entry is written in the cycle after
    // its read, so a sweep never reads an entry it has still to write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_busy <= 1'b0;
            r_rd_idx  <= '0;
            r_b_vld   <= 1'b0;
            r_b_last  <= 1'b0;
        end else begin
            r_b_vld  <= r_rd_busy;
            r_b_last <= r_rd_busy && (r_rd_idx == EW'(NT - 1));
            if (i_start) begin
                r_rd_busy <= 1'b1;
                r_rd_idx  <= '0;
            end else if (r_rd_busy) begin
                if (r_rd_idx == EW'(NT - 1)) begin
                    r_rd_busy <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + EW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_idx <= r_rd_idx;
    end

    // entry update
    assign w_cur = r_vbit[r_b_idx] ? w_rdata : tds_pkg::NEVER_DELAY;
    assign w_use = CW'(r_b_idx) < CW'(i_cmd.n_use);
    assign w_hit = i_cmd.hit_ok && (r_b_idx == i_cmd.idx);

    always_comb begin
        n_val = w_cur;
        n_run = r_run[r_b_idx];
        n_due = 1'b0;
        unique case (i_cmd.mode)
            tds_pkg::MODE_SCHEDULE: begin
                if (w_hit) begin
                    if (i_cmd.dv != '0) begin
                        n_val = i_cmd.dv;
                    end else begin
                        n_run = 1'b1;
                    end
                end
            end
            tds_pkg::MODE_ADVANCE: begin
                if (w_use && (w_cur != tds_pkg::NEVER_DELAY)) begin
                    n_val = (w_cur >= i_cmd.dv) ? (w_cur - i_cmd.dv) : '0;
                end
            end
            tds_pkg::MODE_DISPATCH: begin
                if (w_use) begin
                    n_due = (w_cur == '0) || r_run[r_b_idx];
                    n_run = 1'b0;
                end
            end
            tds_pkg::MODE_FINISH: begin
                if (w_hit) begin
                    n_val = i_cmd.dv;
                end
            end
            default: begin
            end
        endcase
    end

    // flags and due mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbit <= '0;
            r_run  <= '0;
        end else if (r_b_vld) begin
            r_vbit[r_b_idx] <= 1'b1;
            r_run[r_b_idx]  <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_due <= '0;
        end else if (r_b_vld) begin
            r_due[r_b_idx] <= n_due;
        end
    end

    // min stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld  <= 1'b0;
            r_c_last <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_c_vld  <= r_b_vld;
            r_c_last <= r_b_vld && r_b_last;
            r_done   <= r_c_vld && r_c_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_use <= w_use;
        r_c_val <= n_val;
        if (i_start) begin
            r_min <= tds_pkg::NEVER_DELAY;
        end else if (r_c_vld && r_c_use && (r_c_val < r_min)) begin
            r_min <= r_c_val;
        end
    end

    // entries in use
    always_comb begin
        for (int i = 0; i < NT; i++) begin
            w_use_mask[i] = CW'(i) < CW'(i_cmd.n_use);
        end
    end

    assign o_sts.done        = r_done;
    assign o_sts.due_mask    = r_due;
    assign o_sts.min_delay   = r_min;
    assign o_sts.run_pending = |(r_run & w_use_mask);

endmodule

FILE: rtl/task_delay_scheduler.sv
// flow: an accepted word is latched, swept over every entry through the read,
// modify and min stages, summarised, then emitted; each further dispatch word
// is registered once the result channel frees; one word in flight: the next
// word is taken the cycle after the last result is registered; the sweep walks
// the delay memory one entry per cycle (one read and one write port)
// reset: synchronous, active low; all timers read as never, flags cleared
`include "task_delay_scheduler_assert.svh"

module task_delay_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [2:0]  i_task_index,
    input  logic [31:0] i_delay_value,
    input  logic        i_from_irq,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_due_task,
    output logic        o_due_valid,
    output logic        o_last,
    output logic [31:0] o_min_delay,
    output logic        o_run_pending,
    output logic        o_wake,
    // task count register
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata
);

    localparam int NT = tds_pkg::MAX_TASKS;
    localparam int EW = tds_pkg::ENT_W;
    localparam int NW = tds_pkg::CNT_W;
    localparam int DW = tds_pkg::DELAY_BITS;
    localparam int CW = tds_pkg::CMP_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [3:0]          r_task_count;
    logic                r_wake;
    tds_pkg::t_cmd       r_cmd;
    tds_pkg::t_sweep_sts w_sts;
    logic [NT-1:0]       r_due;
    logic [DW-1:0]       r_min;
    logic                r_pend;

    logic                r_out_valid;
    logic [2:0]          r_due_task;
    logic                r_due_valid;
    logic                r_last;
    logic [31:0]         r_min_delay;
    logic                r_run_pending;
    logic                r_out_wake;

    logic                w_in_acc;
    logic                w_out_free;
    logic [NW-1:0]       w_n_use;
    logic [DW-1:0]       w_dv;
    logic                w_hit_ok;
    logic [EW-1:0]       w_pick;
    logic [NT-1:0]       w_rest;
    logic                w_has;
    logic                w_emit_last;

    assign o_ready    = (r_state == S_IDLE);
    assign w_in_acc   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    // task count register; the count in use is clamped to the table size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= tds_pkg::TASK_COUNT_RST;
        end else if (i_cfg_we) begin
            r_task_count <= i_cfg_wdata;
        end
    end

    assign w_n_use  = (CW'(r_task_count) > CW'(NT)) ? NW'(NT) : NW'(r_task_count);
    assign w_dv     = DW'(i_delay_value);
    assign w_hit_ok = CW'(i_task_index) < CW'(w_n_use);

    // latch the command word
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd.mode   <= i_mode;
            r_cmd.idx    <= EW'(i_task_index);
            r_cmd.hit_ok <= w_hit_ok;
            r_cmd.dv     <= w_dv;
            r_cmd.n_use  <= w_n_use;
        end
    end

    // wake flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake <= 1'b0;
        end else if (w_in_acc) begin
            unique case (i_mode)
                tds_pkg::MODE_SCHEDULE: begin
                    if (w_hit_ok && ((w_dv == '0) || i_from_irq)) begin
                        r_wake <= 1'b1;
                    end
                end
                tds_pkg::MODE_ADVANCE: begin
                    r_wake <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    tds_sweep u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_cmd   (r_cmd),
        .o_sts   (w_sts)
    );

    // lowest due entry
    always_comb begin
        w_pick = '0;
        for (int i = NT - 1; i >= 0; i--) begin
            if (r_due[i]) begin
                w_pick = EW'(i);
            end
        end
    end

    assign w_rest      = r_due & ~(NT'(1) << w_pick);
    assign w_has       = (r_cmd.mode == tds_pkg::MODE_DISPATCH) && (r_due != '0);
    assign w_emit_last = !w_has || (w_rest == '0);

    // control sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (w_sts.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free && w_emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sweep summary
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SWEEP) && w_sts.done) begin
            r_due  <= w_sts.due_mask;
            r_min  <= w_sts.min_delay;
            r_pend <= w_sts.run_pending;
        end else if ((r_state == S_EMIT) && w_out_free && w_has) begin
            r_due <= w_rest;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_out_free) begin
            r_due_task    <= w_has ? 3'(w_pick) : 3'd0;
            r_due_valid   <= w_has;
            r_last        <= w_emit_last;
            r_min_delay   <= 32'(r_min);
            r_run_pending <= r_pend;
            r_out_wake    <= r_wake;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_due_task    = r_due_task;
    assign o_due_valid   = r_due_valid;
    assign o_last        = r_last;
    assign o_min_delay   = r_min_delay;
    assign o_run_pending = r_run_pending;
    assign o_wake        = r_out_wake;

    // checks
    `TDS_ASSERT_NXT(a_one_word, w_in_acc, !o_ready, "second word taken during a sweep")
    `TDS_ASSERT_IMP(a_done_in_sweep, w_sts.done, r_state == S_SWEEP, "sweep end outside sweep")
    `TDS_ASSERT_IMP(a_status_word, o_valid && !o_due_valid, o_last && (o_due_task == 3'd0), "status word malformed")
    `TDS_ASSERT_IMP(a_dispatch_clear, o_valid && o_due_valid, !o_run_pending, "run-now left after dispatch")

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int                    MAX_TASKS      = tds_pkg::MAX_TASKS;
    localparam int                    DELAY_BITS     = tds_pkg::DELAY_BITS;
    localparam logic [DELAY_BITS-1:0] NEVER_DELAY    = tds_pkg::NEVER_DELAY;
    localparam logic [3:0]            TASK_COUNT_RST = tds_pkg::TASK_COUNT_RST;
    localparam logic [2:0]            MODE_SCHEDULE  = tds_pkg::MODE_SCHEDULE;
    localparam logic [2:0]            MODE_ADVANCE   = tds_pkg::MODE_ADVANCE;
    localparam logic [2:0]            MODE_DISPATCH  = tds_pkg::MODE_DISPATCH;
    localparam logic [2:0]            MODE_FINISH    = tds_pkg::MODE_FINISH;

    // query and the unused codes above it
    localparam logic [2:0] MODE_QUERY = 3'd4;
    localparam logic [2:0] MODE_LAST  = 3'd7;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [2:0]            mode;
        logic [2:0]            idx;
        logic [DELAY_BITS-1:0] dv;
        logic                  irq;
    } t_cmd_word;

    typedef struct packed {
        logic [2:0]            due_task;
        logic                  due_valid;
        logic                  last;
        logic [DELAY_BITS-1:0] min_delay;
        logic                  run_pending;
        logic                  wake;
    } t_status_word;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_PATTERN, RDY_BURSTY, RDY_COIN} t_rdy_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_mode = '0;
    logic [2:0]  i_task_index = '0;
    logic [31:0] i_delay_value = '0;
    logic        i_from_irq = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_due_task;
    logic        o_due_valid;
    logic        o_last;
    logic [31:0] o_min_delay;
    logic        o_run_pending;
    logic        o_wake;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_wdata = '0;

    task_delay_scheduler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_task_index  (i_task_index),
        .i_delay_value (i_delay_value),
        .i_from_irq    (i_from_irq),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_due_task    (o_due_task),
        .o_due_valid   (o_due_valid),
        .o_last        (o_last),
        .o_min_delay   (o_min_delay),
        .o_run_pending (o_run_pending),
        .o_wake        (o_wake),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // shadow of the timer table
    logic [DELAY_BITS-1:0] tmr_delay [MAX_TASKS];
    logic                  tmr_run   [MAX_TASKS];
    logic                  tmr_wake;
    logic [3:0]            tmr_count;

    t_cmd_word    cmd_q[$];
    t_status_word status_q[$];

    t_cmd_word   cur_cmd = '0;
    int unsigned cmd_accepts = 0;
    int unsigned drv_seen = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    logic        hold_off = 1'b0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;

    int unsigned rcv_cycle = 0;
    t_rdy_style  rcv_style = RDY_ALWAYS;
    logic [15:0] rcv_pat = '1;
    int          stall_left = 0;

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int tasks_in_use();
        return (int'(tmr_count) > MAX_TASKS) ? MAX_TASKS : int'(tmr_count);
    endfunction

    // status word as seen after the current command
    function automatic t_status_word table_status(input logic [2:0] due, input logic valid,
                                                  input logic last);
        t_status_word s;
        int n;
        n = tasks_in_use();
        s.due_task    = due;
        s.due_valid   = valid;
        s.last        = last;
        s.min_delay   = NEVER_DELAY;
        s.run_pending = 1'b0;
        s.wake        = tmr_wake;
        for (int i = 0; i < n; i++) begin
            if (tmr_delay[i] < s.min_delay) s.min_delay = tmr_delay[i];
            if (tmr_run[i]) s.run_pending = 1'b1;
        end
        return s;
    endfunction

    // update the shadow table and queue the status words a command causes
    function automatic void apply_command(input t_cmd_word c);
        int n;
        int cnt;
        int due_list [MAX_TASKS];
        n = tasks_in_use();
        cnt = 0;
        case (c.mode)
            MODE_SCHEDULE: begin
                if (int'(c.idx) < n) begin
                    if (c.dv != '0) begin
                        tmr_delay[c.idx] = c.dv;
                    end else begin
                        tmr_run[c.idx] = 1'b1;
                        tmr_wake = 1'b1;
                    end
                    if (c.irq) tmr_wake = 1'b1;
                end
            end
            MODE_ADVANCE: begin
                for (int i = 0; i < n; i++) begin
                    if (tmr_delay[i] != NEVER_DELAY)
                        tmr_delay[i] = (tmr_delay[i] >= c.dv) ? tmr_delay[i] - c.dv : '0;
                end
                tmr_wake = 1'b0;
            end
            MODE_DISPATCH: begin
                for (int i = 0; i < n; i++) begin
                    if (tmr_delay[i] == '0 || tmr_run[i]) begin
                        due_list[cnt] = i;
                        cnt++;
                    end
                    tmr_run[i] = 1'b0;
                end
            end
            MODE_FINISH: begin
                if (int'(c.idx) < n) tmr_delay[c.idx] = c.dv;
            end
            default: begin
            end
        endcase
        if (c.mode == MODE_DISPATCH && cnt > 0) begin
            for (int k = 0; k < cnt; k++)
                status_q.push_back(table_status(3'(due_list[k]), 1'b1, k == cnt - 1));
        end else begin
            status_q.push_back(table_status(3'd0, 1'b0, 1'b1));
        end
    endfunction

    // result check and command capture at the rising edge
    always @(posedge i_clk) begin : watch_ports
        t_status_word got;
        t_status_word want;
        t_cmd_word    taken;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = {o_due_task, o_due_valid, o_last, o_min_delay, o_run_pending, o_wake};
                if (status_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected status word: due %0d/%0b last %0b min %h pend %0b wake %0b",
                                 got.due_task, got.due_valid, got.last, got.min_delay,
                                 got.run_pending, got.wake);
                end else begin
                    want = status_q.pop_front();
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("status mismatch: exp due %0d/%0b last %0b min %h pend %0b wake %0b",
                                     want.due_task, want.due_valid, want.last, want.min_delay,
                                     want.run_pending, want.wake);
                            $display("                 got due %0d/%0b last %0b min %h pend %0b wake %0b",
                                     got.due_task, got.due_valid, got.last, got.min_delay,
                                     got.run_pending, got.wake);
                        end
                    end
                end
            end
            if (i_valid && o_ready) begin
                taken = {i_mode, i_task_index, i_delay_value, i_from_irq};
                apply_command(taken);
                cmd_accepts++;
            end
        end
    end

    // command driver: bursts of words with random gaps
    always @(negedge i_clk) begin : drive_cmds
        logic nxt_valid;
        nxt_valid = i_valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!i_valid || cmd_accepts != drv_seen) begin
            drv_seen = cmd_accepts;
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (!hold_off && cmd_q.size() > 0) begin
                cur_cmd = cmd_q.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(12, 1);
                    gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
                end
            end
        end
        i_valid       <= nxt_valid;
        i_mode        <= cur_cmd.mode;
        i_task_index  <= cur_cmd.idx;
        i_delay_value <= cur_cmd.dv;
        i_from_irq    <= cur_cmd.irq;
    end

    // result receiver: stalls the result channel in a style that is re-picked at random
    always @(negedge i_clk) begin : stall_results
        logic nxt_ready;
        rcv_cycle++;
        if (rcv_cycle % 128 == 0) begin
            rcv_style = t_rdy_style'($urandom_range(3, 0));
            rcv_pat = 16'($urandom);
        end
        case (rcv_style)
            RDY_ALWAYS: nxt_ready = 1'b1;
            RDY_PATTERN: begin
                nxt_ready = rcv_pat[0];
                rcv_pat = {rcv_pat[0], rcv_pat[15:1]};
            end
            RDY_BURSTY: begin
                if (stall_left > 0) begin
                    stall_left--;
                    nxt_ready = 1'b0;
                end else begin
                    nxt_ready = 1'b1;
                    if ($urandom_range(9, 0) == 0) stall_left = $urandom_range(24, 1);
                end
            end
            default: nxt_ready = 1'($urandom_range(1, 0));
        endcase
        i_ready <= nxt_ready;
    end

    // watchdog
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic push_cmd(input logic [2:0] mode, input logic [2:0] idx,
                            input logic [31:0] dv, input logic irq);
        cmd_q.push_back('{mode: mode, idx: idx, dv: dv, irq: irq});
    endtask

    // wait for the queue to drain and every status word to come back
    task automatic wait_idle();
        while (cmd_q.size() != 0 || i_valid || status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_task_count(input logic [3:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        tmr_count = value;
    endtask

    // mostly schedule/advance/dispatch/finish traffic with small delays
    task automatic add_random_cmds(input int count);
        int n;
        int pick;
        logic [2:0]  m;
        logic [2:0]  ix;
        logic [31:0] dv;
        n = tasks_in_use();
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99, 0);
            if (pick < 32) m = MODE_SCHEDULE;
            else if (pick < 52) m = MODE_ADVANCE;
            else if (pick < 72) m = MODE_DISPATCH;
            else if (pick < 87) m = MODE_FINISH;
            else m = 3'($urandom_range(MODE_LAST, MODE_QUERY));
            if (n > 0 && $urandom_range(9, 0) != 0) ix = 3'($urandom_range(n - 1, 0));
            else ix = 3'($urandom_range(7, 0));
            pick = $urandom_range(99, 0);
            if (m == MODE_ADVANCE) begin
                if (pick < 70) dv = $urandom_range(6, 0);
                else if (pick < 85) dv = $urandom_range(1000, 0);
                else if (pick < 93) dv = $urandom;
                else dv = NEVER_DELAY;
            end else begin
                if (pick < 20) dv = '0;
                else if (pick < 60) dv = $urandom_range(15, 1);
                else if (pick < 75) dv = $urandom_range(5000, 16);
                else if (pick < 88) dv = $urandom;
                else dv = NEVER_DELAY;
            end
            push_cmd(m, ix, dv, 1'($urandom_range(1, 0)));
        end
    endtask

    // stimulus sequence
    initial begin : run_test
        logic [3:0] phase_counts [7];
        for (int i = 0; i < MAX_TASKS; i++) begin
            tmr_delay[i] = NEVER_DELAY;
            tmr_run[i]   = 1'b0;
        end
        tmr_wake  = 1'b0;
        tmr_count = TASK_COUNT_RST;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: reset state, undefined code, empty dispatch, timers and run-now
        push_cmd(MODE_QUERY, 3'd0, 32'd0, 1'b0);
        push_cmd(MODE_LAST, 3'd7, NEVER_DELAY, 1'b1);
        push_cmd(MODE_DISPATCH, 3'd0, 32'd0, 1'b0);
        push_cmd(MODE_SCHEDULE, 3'd0, 32'd0, 1'b0);
        push_cmd(MODE_SCHEDULE, 3'd7, NEVER_DELAY, 1'b1);
        push_cmd(MODE_SCHEDULE, 3'd3, 32'd1, 1'b0);
        push_cmd(MODE_SCHEDULE, 3'd5, 32'hFFFF_FFFE, 1'b1);
        push_cmd(MODE_ADVANCE, 3'd0, 32'd0, 1'b0);
        push_cmd(MODE_ADVANCE, 3'd0, 32'd1, 1'b0);
        push_cmd(MODE_DISPATCH, 3'd0, 32'd0, 1'b0);
        push_cmd(MODE_DISPATCH, 3'd0, 32'd0, 1'b0);
        push_cmd(MODE_FINISH, 3'd3, NEVER_DELAY, 1'b0);
        push_cmd(MODE_FINISH, 3'd6, 32'd0, 1'b0);
        push_cmd(MODE_SCHEDULE, 3'd1, 32'd0, 1'b1);
        push_cmd(MODE_ADVANCE, 3'd0, NEVER_DELAY, 1'b0);
        push_cmd(MODE_DISPATCH, 3'd0, 32'd0, 1'b0);
        push_cmd(MODE_FINISH, 3'd7, 32'd5, 1'b1);
        wait_idle();

        // no entries in use
        write_task_count(4'd0);
        push_cmd(MODE_SCHEDULE, 3'd0, 32'd0, 1'b1);
        push_cmd(MODE_DISPATCH, 3'd0, 32'd0, 1'b0);
        push_cmd(MODE_QUERY, 3'd0, 32'd0, 1'b0);
        wait_idle();

        // count above the table clamps
        write_task_count(4'd15);
        push_cmd(MODE_DISPATCH, 3'd0, 32'd0, 1'b0);
        wait_idle();

        // one entry: index beyond count is ignored
        write_task_count(4'd1);
        push_cmd(MODE_SCHEDULE, 3'd4, 32'd0, 1'b1);
        push_cmd(MODE_FINISH, 3'd7, 32'd0, 1'b0);
        push_cmd(MODE_SCHEDULE, 3'd0, 32'd0, 1'b0);
        push_cmd(MODE_DISPATCH, 3'd0, 32'd0, 1'b0);
        wait_idle();

        // random phases over several table sizes
        phase_counts[0] = 4'd8;
        phase_counts[1] = 4'd1;
        phase_counts[2] = 4'd15;
        phase_counts[3] = 4'($urandom_range(7, 2));
        phase_counts[4] = 4'd0;
        phase_counts[5] = 4'($urandom_range(15, 0));
        phase_counts[6] = 4'd8;
        for (int p = 0; p < 7; p++) begin
            write_task_count(phase_counts[p]);
            add_random_cmds(44);
            if (p == 3) begin
                // hold the sender mid-stream until every status word is back
                while (cmd_q.size() > 20) @(posedge i_clk);
                hold_off = 1'b1;
                while (i_valid || status_q.size() != 0) @(posedge i_clk);
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end
            wait_idle();
        end

        if (err_count == 0 && status_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
